FILE: rtl/lmlt_pkg.sv
// Package for the LCD mode and scanline timing block.
// Holds timing constants, mode and register codes, and the shared structs.
// No dependencies; every other file imports it.
package lmlt_pkg;

  localparam int DOT_W  = 9;
  localparam int LINE_W = 8;
  localparam int MODE_W = 2;

  localparam logic [DOT_W-1:0]  DOTS_PER_LINE     = 9'd456;
  localparam logic [LINE_W-1:0] VBLANK_START_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;
  localparam logic [DOT_W-1:0]  OAM_SCAN_DOTS     = 9'd80;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_DRAW_END_DOT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_STAT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_IRQ_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IRQ_ENABLE  = 3'd5;

  localparam logic [DOT_W-1:0] DRAW_END_DOT_RESET = 9'd252;

  typedef struct packed {
    logic [DOT_W-1:0]  draw_end_dot;
    logic [LINE_W-1:0] line_compare;
    logic              hblank_irq_enable;
    logic              vblank_stat_enable;
    logic              scan_irq_enable;
    logic              match_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic [DOT_W-1:0]  dot;
    logic              line_match;
    logic              vblank_irq;
    logic              stat_irq;
    logic              frame_end;
    logic              fifo_clear;
    logic              fifo_reset;
  } res_t;

endpackage

FILE: rtl/lmlt_if.sv
// Handshake channel interfaces for the LCD mode and scanline timing block.
// Depends on lmlt_pkg for field widths.
interface lmlt_in_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

interface lmlt_out_if import lmlt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LINE_W-1:0] line;
  logic [DOT_W-1:0]  dot;
  logic              line_match;
  logic              vblank_irq;
  logic              stat_irq;
  logic              frame_end;
  logic              fifo_clear;
  logic              fifo_reset;
  modport source (output valid, output mode, output line, output dot, output line_match,
                  output vblank_irq, output stat_irq, output frame_end, output fifo_clear,
                  output fifo_reset, input ready);
  modport sink (input valid, input mode, input line, input dot, input line_match,
                input vblank_irq, input stat_irq, input frame_end, input fifo_clear,
                input fifo_reset, output ready);
endinterface

interface lmlt_cfg_if import lmlt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lmlt_timing.sv
// Mode, dot and line counters with their next-state logic for one dot tick.
// Depends on lmlt_pkg for constants, mode codes and the cfg_t and res_t structs.
module lmlt_timing import lmlt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic advance,
  input  cfg_t cfg,
  output res_t res
);

  logic [MODE_W-1:0] mode;
  logic [LINE_W-1:0] line;
  logic [DOT_W-1:0]  dot;
  logic              match;

  logic [MODE_W-1:0] mode_next;
  logic [LINE_W-1:0] line_next;
  logic [DOT_W-1:0]  dot_next;
  logic              match_next;
  logic              line_chg;
  logic              stat_mode;
  logic              stat_match;
  logic              vblank_p;
  logic              frame_p;
  logic              clear_p;
  logic              reset_p;

  always_comb begin
    mode_next  = mode;
    line_next  = line;
    dot_next   = dot;
    match_next = match;
    line_chg   = 1'b0;
    stat_mode  = 1'b0;
    stat_match = 1'b0;
    vblank_p   = 1'b0;
    frame_p    = 1'b0;
    clear_p    = 1'b0;
    reset_p    = 1'b0;
    if (advance) begin
      unique case (mode)
        MODE_HBLANK: begin
          if (dot != DOTS_PER_LINE) begin
            dot_next = dot + 1'b1;
          end else begin
            line_next = line + 1'b1;
            dot_next  = '0;
            line_chg  = 1'b1;
            if (line_next == VBLANK_START_LINE) begin
              mode_next = MODE_VBLANK;
              vblank_p  = 1'b1;
              frame_p   = 1'b1;
              stat_mode = cfg.vblank_stat_enable;
            end else begin
              mode_next = MODE_SCAN;
              stat_mode = cfg.scan_irq_enable;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot != DOTS_PER_LINE) begin
            dot_next = dot + 1'b1;
          end else begin
            dot_next = '0;
            line_chg = 1'b1;
            if (line == LAST_LINE) begin
              mode_next = MODE_SCAN;
              stat_mode = cfg.scan_irq_enable;
              line_next = '0;
            end else begin
              line_next = line + 1'b1;
            end
          end
        end
        MODE_SCAN: begin
          if (dot == OAM_SCAN_DOTS) begin
            mode_next = MODE_DRAW;
            clear_p   = 1'b1;
          end else begin
            dot_next = dot + 1'b1;
          end
        end
        MODE_DRAW: begin
          if (dot == cfg.draw_end_dot) begin
            mode_next = MODE_HBLANK;
            reset_p   = 1'b1;
            stat_mode = cfg.hblank_irq_enable;
          end else begin
            dot_next = dot + 1'b1;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
      if (line_chg) begin
        match_next = (line_next == cfg.line_compare);
        stat_match = match_next & cfg.match_irq_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SCAN;
      line  <= '0;
      dot   <= '0;
      match <= 1'b0;
    end else if (step) begin
      mode  <= mode_next;
      line  <= line_next;
      dot   <= dot_next;
      match <= match_next;
    end
  end

  assign res.mode       = mode_next;
  assign res.line       = line_next;
  assign res.dot        = dot_next;
  assign res.line_match = match_next;
  assign res.vblank_irq = vblank_p;
  assign res.stat_irq   = stat_mode | stat_match;
  assign res.frame_end  = frame_p;
  assign res.fifo_clear = clear_p;
  assign res.fifo_reset = reset_p;

endmodule

FILE: rtl/lcd_mode_line_timing_top.sv
// Top level of the LCD mode and scanline timing block: configuration registers,
// request handshake and result register. Depends on lmlt_pkg, lmlt_if and lmlt_timing.
//
// Each request is one dot tick and yields exactly one result, registered and shown
// on the cycle after the request is taken. A new request is taken every clock while
// the result register is empty or its result is being taken in the same cycle, so the
// sustained rate is one tick per cycle, set by the single result register; only
// back-pressure on the result channel slows it. Configuration writes are taken every
// cycle and should be made while no tick is in flight.
module lcd_mode_line_timing_top import lmlt_pkg::*; (
  input logic        clk,
  input logic        rst,
  lmlt_in_if.sink    item,
  lmlt_out_if.source result,
  lmlt_cfg_if.sink   cfg
);

  cfg_t regs;
  res_t res_step;
  res_t res_q;
  logic res_valid;
  logic take;

  assign cfg.ready  = 1'b1;
  assign item.ready = !res_valid || result.ready;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.draw_end_dot       <= DRAW_END_DOT_RESET;
      regs.line_compare       <= '0;
      regs.hblank_irq_enable  <= 1'b0;
      regs.vblank_stat_enable <= 1'b0;
      regs.scan_irq_enable    <= 1'b0;
      regs.match_irq_enable   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DRAW_END_DOT:       regs.draw_end_dot       <= cfg.data;
        REG_LINE_COMPARE:       regs.line_compare       <= cfg.data[LINE_W-1:0];
        REG_HBLANK_IRQ_ENABLE:  regs.hblank_irq_enable  <= cfg.data[0];
        REG_VBLANK_STAT_ENABLE: regs.vblank_stat_enable <= cfg.data[0];
        REG_SCAN_IRQ_ENABLE:    regs.scan_irq_enable    <= cfg.data[0];
        REG_MATCH_IRQ_ENABLE:   regs.match_irq_enable   <= cfg.data[0];
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  lmlt_timing u_timing (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .advance (item.advance),
    .cfg     (regs),
    .res     (res_step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_step;
    end
  end

  assign result.valid      = res_valid;
  assign result.mode       = res_q.mode;
  assign result.line       = res_q.line;
  assign result.dot        = res_q.dot;
  assign result.line_match = res_q.line_match;
  assign result.vblank_irq = res_q.vblank_irq;
  assign result.stat_irq   = res_q.stat_irq;
  assign result.frame_end  = res_q.frame_end;
  assign result.fifo_clear = res_q.fifo_clear;
  assign result.fifo_reset = res_q.fifo_reset;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |-> !item.ready)
    else $error("request taken while a result is held");

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_q.fifo_clear, res_q.fifo_reset, res_q.frame_end}))
    else $error("mode transition pulses overlap");

  a_frame_vblank: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.frame_end) |->
      (res_q.vblank_irq && res_q.mode == MODE_VBLANK && res_q.dot == '0))
    else $error("frame end without vertical blank entry");

  a_clear_draw: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.fifo_clear) |-> (res_q.mode == MODE_DRAW))
    else $error("fifo clear outside pixel draw entry");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for lcd_mode_line_timing_top: dot-tick requests in, mode, line
// and dot results out. Depends on lmlt_pkg and the lmlt_in_if, lmlt_out_if and
// lmlt_cfg_if interfaces.
module tb import lmlt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [19:0] DIRECTED_ADV = 20'b1101_1110_0111_0100_1011;
  localparam int N_ITEMS = 950;
  localparam int QUIET_FROM = 700;

  class scan_timing_tracker;
    cfg_t              regs;
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic [DOT_W-1:0]  dot;
    logic              match;
    res_t              pend;
    res_t              expected_res[$];
    int                errors;

    function new();
      regs = '0;
      regs.draw_end_dot = DRAW_END_DOT_RESET;
      mode = MODE_SCAN;
      line = '0;
      dot = '0;
      match = 1'b0;
      errors = 0;
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DRAW_END_DOT:       regs.draw_end_dot = data[DOT_W-1:0];
        REG_LINE_COMPARE:       regs.line_compare = data[LINE_W-1:0];
        REG_HBLANK_IRQ_ENABLE:  regs.hblank_irq_enable = data[0];
        REG_VBLANK_STAT_ENABLE: regs.vblank_stat_enable = data[0];
        REG_SCAN_IRQ_ENABLE:    regs.scan_irq_enable = data[0];
        REG_MATCH_IRQ_ENABLE:   regs.match_irq_enable = data[0];
        default: ;
      endcase
    endfunction

    function void enter(logic [MODE_W-1:0] m);
      mode = m;
      case (m)
        MODE_VBLANK: begin
          pend.vblank_irq = 1'b1;
          if (regs.vblank_stat_enable) pend.stat_irq = 1'b1;
        end
        MODE_HBLANK: if (regs.hblank_irq_enable) pend.stat_irq = 1'b1;
        MODE_SCAN:   if (regs.scan_irq_enable) pend.stat_irq = 1'b1;
        default: ;
      endcase
    endfunction

    function void next_line(bit to_zero);
      line = to_zero ? '0 : line + 1'b1;
      match = (line == regs.line_compare);
      if (match && regs.match_irq_enable) pend.stat_irq = 1'b1;
    endfunction

    function void note_tick(logic adv);
      pend = '0;
      if (adv) begin
        case (mode)
          MODE_HBLANK: begin
            if (dot != DOTS_PER_LINE) begin
              dot = dot + 1'b1;
            end else begin
              next_line(1'b0);
              dot = '0;
              if (line == VBLANK_START_LINE) begin
                enter(MODE_VBLANK);
                pend.frame_end = 1'b1;
              end else begin
                enter(MODE_SCAN);
              end
            end
          end
          MODE_VBLANK: begin
            if (dot != DOTS_PER_LINE) begin
              dot = dot + 1'b1;
            end else begin
              if (line == LAST_LINE) begin
                enter(MODE_SCAN);
                next_line(1'b1);
              end else begin
                next_line(1'b0);
              end
              dot = '0;
            end
          end
          MODE_SCAN: begin
            if (dot == OAM_SCAN_DOTS) begin
              enter(MODE_DRAW);
              pend.fifo_clear = 1'b1;
            end else begin
              dot = dot + 1'b1;
            end
          end
          default: begin
            if (dot == regs.draw_end_dot) begin
              pend.fifo_reset = 1'b1;
              enter(MODE_HBLANK);
            end else begin
              dot = dot + 1'b1;
            end
          end
        endcase
      end
      pend.mode = mode;
      pend.line = line;
      pend.dot = dot;
      pend.line_match = match;
      expected_res.push_back(pend);
    endfunction

    function void cmp_field(string name, logic [DOT_W-1:0] exp_v, logic [DOT_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_res.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_res.pop_front();
      cmp_field("mode", DOT_W'(exp_r.mode), DOT_W'(got.mode));
      cmp_field("line", DOT_W'(exp_r.line), DOT_W'(got.line));
      cmp_field("dot", exp_r.dot, got.dot);
      cmp_field("line_match", DOT_W'(exp_r.line_match), DOT_W'(got.line_match));
      cmp_field("vblank_irq", DOT_W'(exp_r.vblank_irq), DOT_W'(got.vblank_irq));
      cmp_field("stat_irq", DOT_W'(exp_r.stat_irq), DOT_W'(got.stat_irq));
      cmp_field("frame_end", DOT_W'(exp_r.frame_end), DOT_W'(got.frame_end));
      cmp_field("fifo_clear", DOT_W'(exp_r.fifo_clear), DOT_W'(got.fifo_clear));
      cmp_field("fifo_reset", DOT_W'(exp_r.fifo_reset), DOT_W'(got.fifo_reset));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   n_results = 0;
  int   rx_idle_pct = 0;
  bit   sending = 1'b0;
  bit   held_off = 1'b0;

  scan_timing_tracker sb = new();

  lmlt_in_if  tick_ch();
  lmlt_out_if res_ch();
  lmlt_cfg_if cfg_ch();

  lcd_mode_line_timing_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.mode = res_ch.mode;
      got.line = res_ch.line;
      got.dot = res_ch.dot;
      got.line_match = res_ch.line_match;
      got.vblank_irq = res_ch.vblank_irq;
      got.stat_irq = res_ch.stat_irq;
      got.frame_end = res_ch.frame_end;
      got.fifo_clear = res_ch.fifo_clear;
      got.fifo_reset = res_ch.fifo_reset;
      sb.check_result(got);
      n_results++;
    end
  end

  // The long hold-off lets the single result register fill so the block stalls requests.
  initial begin
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && sending && n_results >= 300) begin
        held_off = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_tick(logic adv);
    tick_ch.valid <= 1'b1;
    tick_ch.advance <= adv;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    sb.note_tick(adv);
    @(negedge clk);
  endtask

  task automatic run_ticks(int n, int adv_pct, int tx_idle_pct);
    sending = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      send_tick($urandom_range(99) < adv_pct);
    end
    tick_ch.valid <= 1'b0;
    sending = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.note_write(idx, data);
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] enable_data(int phase);
    if (phase == 1) return '1;
    if (phase == 2) return 9'h1FE;
    return CFG_DATA_W'($urandom_range(0, 511));
  endfunction

  function automatic int idle_pick();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // Early phases pin the extremes; a draw end below the scan end wraps the dot counter
  // before horizontal blank, and one past the line length wraps it during horizontal blank.
  task automatic set_phase_regs(int phase);
    logic [DOT_W-1:0]      draw_end;
    logic [LINE_W-1:0]     cmp;
    logic [CFG_DATA_W-1:0] cmp_data;
    case (phase)
      1: draw_end = 9'd81;
      2: draw_end = 9'd455;
      3: draw_end = 9'd0;
      4: draw_end = 9'd511;
      5: draw_end = 9'd80;
      default: begin
        case ($urandom_range(9))
          0: draw_end = DOT_W'($urandom_range(0, 511));
          1: draw_end = $urandom_range(1) ? 9'd81 : 9'd455;
          default: draw_end = DOT_W'($urandom_range(81, 455));
        endcase
      end
    endcase
    if (phase == 1) begin
      cmp = 8'd255;
    end else if (phase == 2) begin
      cmp = 8'd0;
    end else begin
      case ($urandom_range(3))
        0: cmp = LINE_W'($urandom_range(0, 255));
        1: cmp = $urandom_range(1) ? 8'd0 : 8'd255;
        default: cmp = sb.line + LINE_W'($urandom_range(0, 3));
      endcase
    end
    cmp_data = {1'b0, cmp};
    cmp_data[CFG_DATA_W-1] = 1'($urandom_range(1));
    write_reg(REG_DRAW_END_DOT, draw_end);
    write_reg(REG_LINE_COMPARE, cmp_data);
    write_reg(REG_HBLANK_IRQ_ENABLE, enable_data(phase));
    write_reg(REG_VBLANK_STAT_ENABLE, enable_data(phase));
    write_reg(REG_SCAN_IRQ_ENABLE, enable_data(phase));
    write_reg(REG_MATCH_IRQ_ENABLE, enable_data(phase));
    if ($urandom_range(5) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'($urandom_range(0, 511)));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int n_ticks;
    int adv_pct;
    int tx_idle;
    int phase;
    int total;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.advance = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 20; i++) send_tick(DIRECTED_ADV[i]);
    tick_ch.valid <= 1'b0;
    drain();

    phase = 1;
    total = 20;
    while (total < N_ITEMS) begin
      set_phase_regs(phase);
      if (total < QUIET_FROM) begin
        tx_idle = idle_pick();
        rx_idle_pct = idle_pick();
      end else begin
        tx_idle = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: adv_pct = 50;
        1: adv_pct = 100;
        default: adv_pct = 92;
      endcase
      n_ticks = $urandom_range(60, 160);
      if (n_ticks > N_ITEMS - total) n_ticks = N_ITEMS - total;
      run_ticks(n_ticks, adv_pct, tx_idle);
      drain();
      total += n_ticks;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
rtl/lmlt_pkg.sv
rtl/lmlt_if.sv
rtl/lmlt_timing.sv
rtl/lcd_mode_line_timing_top.sv
bench/tb.sv
